### rtl/psu_pkg.sv
`default_nettype none
package psu_pkg;

	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int PIXEL_BYTES   = 4;
	localparam int ROW_BYTES_MAX = MAX_WIDTH * PIXEL_BYTES;

	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int COL_W    = $clog2(ROW_BYTES_MAX);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int SLOT_W   = $clog2(PIXEL_BYTES);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// register map, decoded on paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// filter type codes as they stand in the stream
	localparam logic [7:0] CODE_NONE  = 8'd0;
	localparam logic [7:0] CODE_SUB   = 8'd1;
	localparam logic [7:0] CODE_UP    = 8'd2;
	localparam logic [7:0] CODE_AVG   = 8'd3;
	localparam logic [7:0] CODE_PAETH = 8'd4;

	typedef enum logic [2:0] {
		FLT_NONE,
		FLT_SUB,
		FLT_UP,
		FLT_AVG,
		FLT_PAETH,
		FLT_BAD
	} filt_t;

	typedef struct packed {
		logic [7:0]       data;
		filt_t            filt;
		logic [COL_W-1:0] col;
		logic             left_edge;
		logic             first_row;
		logic             eor;
		logic             eoi;
	} item_t;

	typedef struct packed {
		logic             restart;
		logic [COL_W-1:0] last_col;
		logic [ROW_W-1:0] last_row;
	} geom_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic filt_t classify(input logic [7:0] code);
		filt_t f;
		unique case (code)
			CODE_NONE:  f = FLT_NONE;
			CODE_SUB:   f = FLT_SUB;
			CODE_UP:    f = FLT_UP;
			CODE_AVG:   f = FLT_AVG;
			CODE_PAETH: f = FLT_PAETH;
			default:    f = FLT_BAD;
		endcase
		return f;
	endfunction

endpackage
`default_nettype wire

### rtl/png_scanline_unfilter_unit.sv
// PNG scanline unfilter, 8-bit RGBA.
// Input channel (data_valid / data_stall / data_byte): the inflated image
// stream, one item per byte. The first byte of each row is its filter type
// and yields no result; each following byte yields one result item on the
// pixel channel (pixel_valid / pixel_stall / pixel_byte, end_of_row,
// end_of_image). After the last byte of the image the next byte is again the
// filter type of row 0.
// Throughput: one item per cycle sustained while pixel_stall is low. A sample
// byte passes through the queue, then the line buffer read and reconstruction
// stage, then the output register before it appears on the pixel channel.
// The front end counts columns and rows and tags each sample; a four-entry
// queue decouples it from the back end, which reads the upper row from a
// single line buffer RAM (one read, one write port) and writes the rebuilt
// byte back.
// When pixel_stall is high the result holds, the back end freezes and the
// queue fills; data_stall rises only when the queue is full.
// Reset: position goes to row 0 awaiting a filter byte, width and height
// read as 1. The line buffer is not cleared; the first row never reads it.
// A write to either register also restarts the image.
// Registers (APB, byte address): 0x0 image_width, 0x4 image_height.
`default_nettype none
module png_scanline_unfilter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	input  wire logic        data_valid,
	output      logic        data_stall,
	input  wire logic [7:0]  data_byte,
	output      logic        pixel_valid,
	input  wire logic        pixel_stall,
	output      logic [7:0]  pixel_byte,
	output      logic        end_of_row,
	output      logic        end_of_image
);
	import psu_pkg::*;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [WIDTH_W-1:0]  w_c;
	logic [HEIGHT_W-1:0] h_c;
	logic [COL_W:0]      row_len;
	logic                cfg_we;
	geom_t               geom;
	qstat_t              qstat;
	item_t               push_item;
	item_t               head;
	logic                push;
	logic                pop;

	// --- configuration port ---
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(1);
			height_q <= HEIGHT_W'(1);
		end else if (cfg_we) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= pwdata[HEIGHT_W-1:0];
				default:    width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = {{(32-WIDTH_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32-HEIGHT_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	// zero counts as one, anything over the maximum saturates
	always_comb begin
		if (width_q == '0) begin
			w_c = WIDTH_W'(1);
		end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
			w_c = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_c = width_q;
		end
		if (height_q == '0) begin
			h_c = HEIGHT_W'(1);
		end else if (height_q > HEIGHT_W'(MAX_HEIGHT)) begin
			h_c = HEIGHT_W'(MAX_HEIGHT);
		end else begin
			h_c = height_q;
		end
	end

	assign row_len       = (COL_W+1)'(w_c) << SLOT_W;
	assign geom.restart  = cfg_we;
	assign geom.last_col = COL_W'(row_len - 1'b1);
	assign geom.last_row = ROW_W'(h_c - 1'b1);

	// --- front: row/column tracking, filter classification ---
	psu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_byte (data_byte),
		.geom      (geom),
		.qstat     (qstat),
		.push      (push),
		.item      (push_item)
	);

	psu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// --- back: line buffer, reconstruction, output register ---
	psu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_byte  (pixel_byte),
		.end_of_row  (end_of_row),
		.end_of_image(end_of_image)
	);

	// --- checks ---
	a_eoi_on_eor: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && end_of_image |-> end_of_row)
		else $error("end_of_image without end_of_row");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

### rtl/psu_ram.sv
`default_nettype none
module psu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### rtl/psu_front.sv
`default_nettype none
module psu_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           data_valid,
	output      logic           data_stall,
	input  wire logic [7:0]     data_byte,
	input  wire psu_pkg::geom_t geom,
	input  wire psu_pkg::qstat_t qstat,
	output      logic           push,
	output      psu_pkg::item_t item
);
	import psu_pkg::*;

	logic             awaiting_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	filt_t            filt_q;
	logic             accept;
	logic             eor;
	logic             eoi;

	assign data_stall = qstat.full;
	assign accept     = data_valid && !qstat.full;
	assign push       = accept && !awaiting_q;

	assign eor = (col_q == geom.last_col);
	assign eoi = eor && (row_q == geom.last_row);

	always_comb begin
		item.data      = data_byte;
		item.filt      = filt_q;
		item.col       = col_q;
		item.left_edge = (col_q[COL_W-1:SLOT_W] == '0);
		item.first_row = (row_q == '0);
		item.eor       = eor;
		item.eoi       = eoi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			col_q      <= '0;
			row_q      <= '0;
			filt_q     <= FLT_NONE;
		end else if (geom.restart) begin
			awaiting_q <= 1'b1;
			col_q      <= '0;
			row_q      <= '0;
			filt_q     <= FLT_NONE;
		end else if (accept) begin
			if (awaiting_q) begin
				filt_q     <= classify(data_byte);
				awaiting_q <= 1'b0;
				col_q      <= '0;
			end else if (eor) begin
				awaiting_q <= 1'b1;
				col_q      <= '0;
				row_q      <= eoi ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/psu_queue.sv
`default_nettype none
module psu_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire psu_pkg::item_t  push_item,
	input  wire logic            pop,
	output      psu_pkg::item_t  head,
	output      psu_pkg::qstat_t qstat
);
	import psu_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/psu_back.sv
`default_nettype none
module psu_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire psu_pkg::item_t  head,
	input  wire psu_pkg::qstat_t qstat,
	output      logic            pop,
	output      logic            pixel_valid,
	input  wire logic            pixel_stall,
	output      logic [7:0]      pixel_byte,
	output      logic            end_of_row,
	output      logic            end_of_image
);
	import psu_pkg::*;

	item_t             s1_q;
	logic              s1_v_q;
	logic              out_v_q;
	logic [7:0]        pixel_q;
	logic              eor_q;
	logic              eoi_q;
	logic [7:0]        left_q [PIXEL_BYTES];
	logic [7:0]        ul_q   [PIXEL_BYTES];
	logic [7:0]        upper;
	logic              out_free;
	logic              s1_go;
	logic [SLOT_W-1:0] slot;
	logic [7:0]        a;
	logic [7:0]        b;
	logic [7:0]        c;
	logic [8:0]        ab_sum;
	logic [9:0]        pa;
	logic [9:0]        pb;
	logic [9:0]        pc;
	logic [7:0]        pred;
	logic [7:0]        r;

	assign out_free = !out_v_q || !pixel_stall;
	assign s1_go    = s1_v_q && out_free;
	assign pop      = !qstat.empty && (!s1_v_q || out_free);

	// upper row line buffer; read as the item leaves the queue
	psu_ram #(
		.WIDTH(8),
		.DEPTH(ROW_BYTES_MAX)
	) u_row_ram (
		.clk  (clk),
		.we   (s1_go),
		.waddr(s1_q.col),
		.wdata(r),
		.re   (pop),
		.raddr(head.col),
		.rdata(upper)
	);

	assign slot = s1_q.col[SLOT_W-1:0];
	assign a    = s1_q.left_edge ? 8'd0 : left_q[slot];
	assign c    = s1_q.left_edge ? 8'd0 : ul_q[slot];
	assign b    = s1_q.first_row ? 8'd0 : upper;

	// Paeth distances: |b-c|, |a-c|, |a+b-2c|
	always_comb begin
		logic signed [9:0] da;
		logic signed [9:0] db;
		logic signed [9:0] dc;
		da = $signed({2'b00, b}) - $signed({2'b00, c});
		db = $signed({2'b00, a}) - $signed({2'b00, c});
		dc = da + db;
		pa = da[9] ? 10'(-da) : da;
		pb = db[9] ? 10'(-db) : db;
		pc = dc[9] ? 10'(-dc) : dc;
	end

	assign ab_sum = {1'b0, a} + {1'b0, b};

	always_comb begin
		if (pa <= pb && pa <= pc) begin
			pred = a;
		end else if (pb <= pc) begin
			pred = b;
		end else begin
			pred = c;
		end
	end

	always_comb begin
		unique case (s1_q.filt)
			FLT_NONE:  r = s1_q.data;
			FLT_SUB:   r = s1_q.data + a;
			FLT_UP:    r = s1_q.data + b;
			FLT_AVG:   r = s1_q.data + ab_sum[8:1];
			FLT_PAETH: r = s1_q.data + pred;
			default:   r = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			s1_q <= head;
		end
		if (s1_go) begin
			pixel_q      <= r;
			eor_q        <= s1_q.eor;
			eoi_q        <= s1_q.eoi;
			left_q[slot] <= r;
			ul_q[slot]   <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				s1_v_q <= 1'b1;
			end else if (s1_go) begin
				s1_v_q <= 1'b0;
			end
			if (s1_go) begin
				out_v_q <= 1'b1;
			end else if (out_free) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign pixel_valid  = out_v_q;
	assign pixel_byte   = pixel_q;
	assign end_of_row   = eor_q;
	assign end_of_image = eoi_q;

endmodule
`default_nettype wire
